/* rtl/core/lbfr_pkg.sv */
// shared types and constants of the led bar frame renderer
`timescale 1ns / 1ps

package lbfr_pkg;

   localparam int MAX_LEDS   = 64;
   localparam int LED_W      = 6;
   localparam int CNT_W      = 7;
   localparam int PCT_W      = 7;
   localparam int COL_W      = 8;
   localparam int PROD_W     = 13;
   localparam int HALF_W     = 6;
   localparam int HOLD_W     = 17;
   localparam int STEP_HOLD_W = 16;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LEDS);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LED_COUNT   = 3'd0,
      REG_SYMMETRIC   = 3'd1,
      REG_BLANK_FILL  = 3'd2,
      REG_SECTOR_STEP = 3'd3,
      REG_SECTOR_HOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
   } rgb_type;

   // products registered at request time, resolved to a window later
   typedef struct packed {
      logic              mode;
      logic              symmetric;
      logic              dpos;
      logic [CNT_W-1:0]  n;
      logic [HALF_W-1:0] h;
      logic [PROD_W-1:0] prod_a;
      logic [PROD_W-1:0] prod_b;
   } frame_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] hi;
   } window_type;

endpackage

/* rtl/core/led_bar_frame_renderer.sv */
// top level of the led bar frame renderer: request register, frame engine, result register
`timescale 1ns / 1ps

// One request transfer asks for one frame; the block answers with one result transfer per
// led, index 0 up to n-1, with tlast on the final led, where n is led_count saturated to 64.
// The frame engine's led counter emits one led per cycle into the result register unless
// the result side stalls, and the next request is taken while the current frame streams, so
// frames follow each other with no gap while rsp_tready stays high. With a led count of zero
// a request is taken and dropped with no results and no change to the sector. Sector mode
// keeps its window edge and hold count across frames; a sector request with leds adds n to
// the hold count, and the edge steps down or wraps once that reaches the sector hold.
// Registers are to be written through the csr channel only while the block is idle; the
// block itself does not enforce this. csr_ready is always high.
module led_bar_frame_renderer (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // percentage, main_red, main_green, main_blue, alt_red, alt_green, alt_blue, zero pad
   input  logic [lbfr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode
   input  logic                                req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // led_index, out_red, out_green, out_blue, zero pad
   output logic [lbfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lbfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbfr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lbfr_pkg::*;

   // configuration registers
   logic [CNT_W-1:0]       led_count_ff;
   logic                   symmetric_ff;
   logic                   blank_fill_ff;
   logic [PCT_W-1:0]       sector_step_ff;
   logic [STEP_HOLD_W-1:0] sector_hold_ff;

   // sector state
   logic [PCT_W-1:0]  sector_end_ff;
   logic [PCT_W-1:0]  sector_end_in;
   logic [HOLD_W-1:0] hold_ff;
   logic [HOLD_W-1:0] hold_in;

   // request register
   logic          p1_valid_ff;
   logic          p1_valid_in;
   frame_req_type p1_req_ff;
   frame_req_type p1_req_in;
   rgb_type       p1_main_ff;
   rgb_type       p1_alt_ff;

   // frame engine
   logic             eng_active_ff;
   logic [LED_W-1:0] led_ff;
   logic [LED_W-1:0] last_idx_ff;
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] hi_ff;
   logic             black_ff;
   rgb_type          eng_main_ff;
   rgb_type          eng_alt_ff;

   // result register
   logic             rsp_valid_ff;
   logic [LED_W-1:0] rsp_led_ff;
   rgb_type          rsp_rgb_ff;
   logic             rsp_last_ff;

   logic             req_fire;
   logic             csr_fire;
   logic [CNT_W-1:0] n_eff;
   logic [PCT_W-1:0] pct_sat;
   logic [PCT_W:0]   end_diff;
   logic             diff_pos;
   logic [PCT_W-1:0] neg_span;
   logic [PCT_W-1:0] op_a;
   logic [PCT_W-1:0] op_b;
   logic [CNT_W-1:0] op_b_n;
   logic [HOLD_W-1:0] hold_sum;
   window_type       win;
   logic             out_free;
   logic             emit;
   logic             eng_last;
   logic             load;
   logic [CNT_W-1:0] led_ext;
   logic             use_main;
   rgb_type          led_rgb;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // --- request side: saturate, multiply, advance sector state

   assign n_eff    = (led_count_ff > CNT_MAX) ? CNT_MAX : led_count_ff;
   assign pct_sat  = (req_tdata[6:0] > PCT_FULL) ? PCT_FULL : req_tdata[6:0];
   // lower sector edge in percent, may go negative
   assign end_diff = {1'b0, sector_end_ff} - {1'b0, sector_step_ff};
   assign diff_pos = !end_diff[PCT_W] && (end_diff != '0);
   // size of the lower edge once it sits at zero or below
   assign neg_span = sector_step_ff - sector_end_ff;

   assign op_a   = req_tuser ? sector_end_ff : pct_sat;
   assign op_b   = req_tuser ? (diff_pos ? end_diff[PCT_W-1:0] : neg_span) : pct_sat;
   assign op_b_n = req_tuser ? n_eff : {1'b0, n_eff[CNT_W-1:1]};

   always_comb begin
      p1_req_in.mode      = req_tuser;
      p1_req_in.symmetric = symmetric_ff;
      p1_req_in.dpos      = diff_pos;
      p1_req_in.n         = n_eff;
      p1_req_in.h         = n_eff[CNT_W-1:1];
      p1_req_in.prod_a    = PROD_W'(op_a) * PROD_W'(n_eff);
      p1_req_in.prod_b    = PROD_W'(op_b) * PROD_W'(op_b_n);
   end

   assign hold_sum = hold_ff + HOLD_W'(n_eff);

   always_comb begin
      hold_in       = hold_ff;
      sector_end_in = sector_end_ff;
      if (req_fire && (n_eff != '0) && req_tuser) begin
         if (hold_sum >= HOLD_W'(sector_hold_ff)) begin
            hold_in       = '0;
            // wrap back to a full sector once the edge reaches zero or below
            sector_end_in = diff_pos ? end_diff[PCT_W-1:0] : PCT_FULL;
         end else begin
            hold_in = hold_sum;
         end
      end
   end

   // --- engine handshake

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = eng_active_ff && out_free;
   assign eng_last   = (led_ff == last_idx_ff);
   assign load       = p1_valid_ff && (!eng_active_ff || (emit && eng_last));
   assign req_tready = !p1_valid_ff || load;
   assign req_fire   = req_tvalid && req_tready;

   // zero-led requests are taken and dropped here
   always_comb begin
      if (req_fire && (n_eff != '0)) begin
         p1_valid_in = 1'b1;
      end else if (load) begin
         p1_valid_in = 1'b0;
      end else begin
         p1_valid_in = p1_valid_ff;
      end
   end

   lbfr_window u_window (
      .req (p1_req_ff),
      .win (win)
   );

   // --- per-led colour choice

   assign led_ext  = {1'b0, led_ff};
   assign use_main = (led_ext >= lo_ff) && (led_ext < hi_ff);

   always_comb begin
      if (use_main) begin
         led_rgb = eng_main_ff;
      end else if (black_ff) begin
         led_rgb = '0;
      end else begin
         led_rgb = eng_alt_ff;
      end
   end

   // --- registers

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff   <= CNT_W'(60);
         symmetric_ff   <= 1'b0;
         blank_fill_ff  <= 1'b0;
         sector_step_ff <= PCT_W'(10);
         sector_hold_ff <= STEP_HOLD_W'(1000);
      end else if (csr_fire) begin
         case (csr_index)
            REG_LED_COUNT:   led_count_ff   <= csr_data[CNT_W-1:0];
            REG_SYMMETRIC:   symmetric_ff   <= csr_data[0];
            REG_BLANK_FILL:  blank_fill_ff  <= csr_data[0];
            REG_SECTOR_STEP: sector_step_ff <= csr_data[PCT_W-1:0];
            REG_SECTOR_HOLD: sector_hold_ff <= csr_data[STEP_HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_end_ff <= PCT_FULL;
         hold_ff       <= '0;
         p1_valid_ff   <= 1'b0;
      end else begin
         sector_end_ff <= sector_end_in;
         hold_ff       <= hold_in;
         p1_valid_ff   <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p1_req_ff  <= p1_req_in;
         p1_main_ff <= '{red: req_tdata[14:7], green: req_tdata[22:15], blue: req_tdata[30:23]};
         p1_alt_ff  <= '{red: req_tdata[38:31], green: req_tdata[46:39], blue: req_tdata[54:47]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eng_active_ff <= 1'b0;
         led_ff        <= '0;
      end else if (load) begin
         eng_active_ff <= 1'b1;
         led_ff        <= '0;
      end else if (emit) begin
         eng_active_ff <= !eng_last;
         led_ff        <= led_ff + LED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff       <= win.lo;
         hi_ff       <= win.hi;
         last_idx_ff <= LED_W'(p1_req_ff.n - CNT_W'(1));
         black_ff    <= !p1_req_ff.mode && !p1_req_ff.symmetric && !blank_fill_ff;
         eng_main_ff <= p1_main_ff;
         eng_alt_ff  <= p1_alt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_led_ff  <= led_ff;
         rsp_rgb_ff  <= led_rgb;
         rsp_last_ff <= eng_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_rgb_ff.blue, rsp_rgb_ff.green, rsp_rgb_ff.red, rsp_led_ff};

endmodule

/* rtl/core/lbfr_window.sv */
// resolves registered percent products into the main-colour led window
`timescale 1ns / 1ps

module lbfr_window (
   input  lbfr_pkg::frame_req_type req,
   output lbfr_pkg::window_type    win
);
   import lbfr_pkg::*;

   localparam int DIV_SHIFT = 19;
   localparam logic [PROD_W-1:0] DIV_MUL = PROD_W'(5243);
   localparam logic [PROD_W-1:0] HUNDRED = PROD_W'(100);

   typedef struct packed {
      logic [CNT_W-1:0] q;
      logic             frac;
   } quot_type;

   // divide by 100 through a reciprocal, exact for the product range here
   function automatic quot_type div100(input logic [PROD_W-1:0] x);
      logic [2*PROD_W-1:0] prod;
      logic [PROD_W-1:0]   back;
      quot_type            res;
      prod     = (2*PROD_W)'(x) * (2*PROD_W)'(DIV_MUL);
      res.q    = prod[DIV_SHIFT +: CNT_W];
      back     = PROD_W'(res.q) * HUNDRED;
      res.frac = (back != x);
      return res;
   endfunction

   quot_type         qa;
   quot_type         qb;
   logic [CNT_W-1:0] idx_a;
   logic [CNT_W-1:0] idx_b;
   logic [CNT_W-1:0] sym_s;

   always_comb begin
      qa    = div100(req.prod_a);
      qb    = div100(req.prod_b);
      idx_a = qa.q + CNT_W'(qa.frac);
      idx_b = qb.q + CNT_W'(qb.frac);
      // end cover count, carries the frac of p*n rather than of p*h
      sym_s = CNT_W'(req.h) - qb.q + CNT_W'(qa.frac);
      if (req.mode) begin
         // an edge below zero truncates toward zero and still rounds up to led one
         // while its product stays under one hundred
         win.lo = req.dpos ? idx_b : CNT_W'((qb.q == '0) && qb.frac);
         win.hi = idx_a;
      end else if (req.symmetric) begin
         win.lo = sym_s;
         win.hi = req.n - sym_s;
      end else begin
         win.lo = '0;
         win.hi = idx_a;
      end
   end

endmodule

/* rtl/core/lbfr_checker.sv */
// port-level checks of the led bar frame renderer, bound to the top level
`timescale 1ns / 1ps

module lbfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lbfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import lbfr_pkg::*;

   logic rsp_fire;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // inside a frame the next led follows at once with the next index
   a_led_next: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_tlast |=> rsp_tvalid
         && (rsp_tdata[LED_W-1:0] == $past(rsp_tdata[LED_W-1:0]) + LED_W'(1)))
      else $error("led sequence broken inside a frame");

   // a new frame starts at led zero
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tlast |=> !rsp_tvalid || (rsp_tdata[LED_W-1:0] == '0))
      else $error("frame did not start at led zero");

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind led_bar_frame_renderer lbfr_checker u_lbfr_checker (.*);

/* bench/testbench.sv */
// self-checking bench for the led bar frame renderer: directed frames, random phases, scoreboard
`timescale 1ns / 1ps

module testbench;
   import lbfr_pkg::*;

   // frame kinds carried in req_tuser
   localparam logic MODE_FILL   = 1'b0;
   localparam logic MODE_SECTOR = 1'b1;

   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 8;
   // bound for the worst run: roughly 400 frames of 64 leds, each led under the longest sink stall
   localparam int RUN_LIMIT_NS    = 30_000_000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PRESSURE_CYCLES = 400;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_FRAMES    = 30;
   localparam int PRESSURE_PHASE  = 5;
   localparam int PCT_LIMIT       = 100;

   typedef struct {
      logic             mode;
      logic [PCT_W-1:0] pct;
      rgb_type          main_c;
      rgb_type          alt_c;
   } frame_cmd_type;

   typedef struct {
      logic [LED_W-1:0] led_index;
      rgb_type          colour;
      logic             last_led;
   } led_expect_type;

   // ------------------------------------------------------------------
   // scoreboard: own copy of the registers and the sector state, and the
   // queue of leds still owed by the block
   // ------------------------------------------------------------------
   class led_frame_board;
      int led_total;
      int symmetric;
      int blank_alt;
      int step_pct;
      int hold_limit;
      int sector_end;
      int hold_acc;
      int failures;
      led_expect_type owed_leds[$];

      function new();
         led_total  = 60;
         symmetric  = 0;
         blank_alt  = 0;
         step_pct   = 10;
         hold_limit = 1000;
         sector_end = PCT_LIMIT;
         hold_acc   = 0;
         failures   = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_LED_COUNT:   led_total  = int'(data[CNT_W-1:0]);
            REG_SYMMETRIC:   symmetric  = int'(data[0]);
            REG_BLANK_FILL:  blank_alt  = int'(data[0]);
            REG_SECTOR_STEP: step_pct   = int'(data[PCT_W-1:0]);
            REG_SECTOR_HOLD: hold_limit = int'(data[STEP_HOLD_W-1:0]);
            default: ;
         endcase
      endfunction

      // ceiling-style led index of a percent, truncating toward zero when negative
      function int ceil_index(int d, int n);
         int prod;
         int mag;
         int q;
         prod = d * n;
         mag  = (prod < 0) ? -prod : prod;
         q    = mag / 100;
         if (prod < 0) q = -q;
         return q + ((mag % 100) != 0 ? 1 : 0);
      endfunction

      function void note_frame(frame_cmd_type f);
         int n, p, lo, hi, s, h, i;
         bit lit, dark;
         led_expect_type e;
         n = (led_total > MAX_LEDS) ? MAX_LEDS : led_total;
         if (n == 0) return;
         p  = (int'(f.pct) > PCT_LIMIT) ? PCT_LIMIT : int'(f.pct);
         lo = 0;
         hi = 0;
         s  = 0;
         if (f.mode == MODE_SECTOR) begin
            hi = ceil_index(sector_end, n);
            lo = ceil_index(sector_end - step_pct, n);
            if (lo < 0) lo = 0;
         end else if (symmetric != 0) begin
            h = n / 2;
            s = h - (p * h) / 100 + (((p * n) % 100) != 0 ? 1 : 0);
         end else begin
            hi = ceil_index(p, n);
         end
         for (i = 0; i < n; i++) begin
            dark = 1'b0;
            if (f.mode == MODE_SECTOR) begin
               lit = (i >= lo && i < hi);
            end else if (symmetric != 0) begin
               lit = !(i < s || i >= n - s);
            end else begin
               lit  = (i < hi);
               dark = !lit && (blank_alt == 0);
            end
            e.led_index = LED_W'(i);
            if (dark) e.colour = '0;
            else if (lit) e.colour = f.main_c;
            else e.colour = f.alt_c;
            e.last_led = (i == n - 1);
            owed_leds.push_back(e);
         end
         if (f.mode == MODE_SECTOR) begin
            hold_acc = (hold_acc + n) & ((1 << HOLD_W) - 1);
            if (hold_acc >= hold_limit) begin
               hold_acc   = 0;
               sector_end = sector_end - step_pct;
               if (sector_end <= 0) sector_end = PCT_LIMIT;
            end
         end
      endfunction

      function void check_led(logic [LED_W-1:0] idx, rgb_type c, logic last);
         led_expect_type e;
         if (owed_leds.size() == 0) begin
            $error("unexpected led transfer: led_index %0d with nothing owed", idx);
            failures++;
            return;
         end
         e = owed_leds.pop_front();
         if (idx !== e.led_index) begin
            $error("led_index mismatch: expected %0d, actual %0d", e.led_index, idx);
            failures++;
         end
         if (c.red !== e.colour.red) begin
            $error("out_red mismatch: expected %0d, actual %0d", e.colour.red, c.red);
            failures++;
         end
         if (c.green !== e.colour.green) begin
            $error("out_green mismatch: expected %0d, actual %0d", e.colour.green, c.green);
            failures++;
         end
         if (c.blue !== e.colour.blue) begin
            $error("out_blue mismatch: expected %0d, actual %0d", e.colour.blue, c.blue);
            failures++;
         end
         if (last !== e.last_led) begin
            $error("last_led mismatch: expected %0d, actual %0d", e.last_led, last);
            failures++;
         end
      endfunction

      function int outstanding();
         return owed_leds.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // block under test
   // ------------------------------------------------------------------
   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   led_frame_board board = new();

   // idling style per phase: calm means back-to-back transfers
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   // one-off long hold-off of the result side, picked up by the sink
   int rsp_hold_off = 0;

   led_bar_frame_renderer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------
   function automatic int draw_gap(bit calm);
      if (calm) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic frame_cmd_type frame_of(logic mode, int pct,
                                              int mr, int mg, int mb, int ar, int ag, int ab);
      frame_cmd_type f;
      f.mode   = mode;
      f.pct    = PCT_W'(pct);
      f.main_c = '{red: COL_W'(mr), green: COL_W'(mg), blue: COL_W'(mb)};
      f.alt_c  = '{red: COL_W'(ar), green: COL_W'(ag), blue: COL_W'(ab)};
      return f;
   endfunction

   function automatic frame_cmd_type random_frame();
      int sel;
      int pct;
      sel = $urandom_range(0, 19);
      // mostly legal percentages, with the ends and the saturating range mixed in
      if (sel == 0) pct = 0;
      else if (sel == 1) pct = PCT_LIMIT;
      else if (sel < 4) pct = $urandom_range(PCT_LIMIT + 1, 127);
      else pct = $urandom_range(0, PCT_LIMIT);
      return frame_of(($urandom_range(0, 9) < 4) ? MODE_SECTOR : MODE_FILL, pct,
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endfunction

   // one request transfer; entered and left at a falling edge, tvalid kept high when
   // the next frame follows without a gap
   task automatic send_frame(frame_cmd_type f);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {1'b0, f.alt_c.blue, f.alt_c.green, f.alt_c.red,
                    f.main_c.blue, f.main_c.green, f.main_c.red, f.pct};
      req_tuser  = f.mode;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_frame(f);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // all owed leds back, then a settle wait in case a zero-led frame is still in flight
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random register setting for one phase; upper csr_data bits are don't-care noise
   task automatic shuffle_registers();
      int sel;
      int val;
      sel = $urandom_range(0, 19);
      if (sel == 0) val = 0;                                   // no leds at all
      else if (sel < 3) val = $urandom_range(MAX_LEDS + 1, 127); // saturates
      else if (sel < 7) val = $urandom_range(17, MAX_LEDS);
      else val = $urandom_range(1, 16);
      write_csr(REG_LED_COUNT, CSR_DATA_W'(($urandom_range(0, 511) << CNT_W) | val));
      write_csr(REG_SYMMETRIC, CSR_DATA_W'($urandom_range(0, 65535)));
      write_csr(REG_BLANK_FILL, CSR_DATA_W'($urandom_range(0, 65535)));
      sel = $urandom_range(0, 9);
      if (sel == 0) val = 0;
      else if (sel == 1) val = 1;
      else if (sel == 2) val = PCT_LIMIT;
      else if (sel == 3) val = $urandom_range(PCT_LIMIT + 1, 127);
      else val = $urandom_range(1, PCT_LIMIT);
      write_csr(REG_SECTOR_STEP, CSR_DATA_W'(($urandom_range(0, 511) << PCT_W) | val));
      sel = $urandom_range(0, 9);
      if (sel == 0) val = 0;
      else if (sel == 1) val = 1;
      else if (sel == 2) val = 65535;
      else if (sel == 3) val = $urandom_range(0, 65535);
      else val = $urandom_range(1, 200);
      write_csr(REG_SECTOR_HOLD, CSR_DATA_W'(val));
      // unused register slots now and then
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_IDX_W'($urandom_range(REG_SECTOR_HOLD + 1, 7)),
                   CSR_DATA_W'($urandom_range(0, 65535)));
   endtask

   // ------------------------------------------------------------------
   // result sink: draws a stall per led, honours the one-off hold-off
   // ------------------------------------------------------------------
   initial begin : led_sink
      int stall;
      rsp_tready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap(rsp_calm);
         if (rsp_hold_off > 0) begin
            stall        = rsp_hold_off;
            rsp_hold_off = 0;
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_led(rsp_tdata[LED_W-1:0],
                         '{red:   rsp_tdata[LED_W +: COL_W],
                           green: rsp_tdata[LED_W + COL_W +: COL_W],
                           blue:  rsp_tdata[LED_W + 2 * COL_W +: COL_W]},
                         rsp_tlast);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : frame_source
      int phase;
      int k;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset values: 60 leds, bar fill, black blanks, step 10, hold 1000
      send_frame(frame_of(MODE_FILL, 0, 'hFF, 'hFF, 'hFF, 'h00, 'h00, 'h00));
      send_frame(frame_of(MODE_FILL, 100, 'h00, 'h00, 'h00, 'hFF, 'hFF, 'hFF));
      // percentage above full scale
      send_frame(frame_of(MODE_FILL, 127, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55));
      send_frame(frame_of(MODE_FILL, 1, 'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA));
      send_frame(frame_of(MODE_SECTOR, 50, 'h12, 'h34, 'h56, 'h78, 'h9A, 'hBC));
      wait_idle();

      // full strip, blanks in second colour
      write_csr(REG_LED_COUNT, CSR_DATA_W'(MAX_LEDS));
      write_csr(REG_BLANK_FILL, 1);
      send_frame(frame_of(MODE_FILL, 50, 'h01, 'h02, 'h04, 'h80, 'h40, 'h20));
      send_frame(frame_of(MODE_FILL, 99, 'hFE, 'hFD, 'hFB, 'h7F, 'hBF, 'hDF));
      wait_idle();

      // symmetric fill on an odd strip
      write_csr(REG_LED_COUNT, 63);
      write_csr(REG_SYMMETRIC, 1);
      send_frame(frame_of(MODE_FILL, 0, 'hFF, 'h00, 'hFF, 'h00, 'hFF, 'h00));
      send_frame(frame_of(MODE_FILL, 100, 'h0F, 'hF0, 'h0F, 'hF0, 'h0F, 'hF0));
      send_frame(frame_of(MODE_FILL, 33, 'h11, 'h22, 'h33, 'h44, 'h55, 'h66));
      send_frame(frame_of(MODE_FILL, 127, 'h99, 'h88, 'h77, 'h66, 'h55, 'h44));
      wait_idle();

      // single led
      write_csr(REG_LED_COUNT, 1);
      send_frame(frame_of(MODE_FILL, 50, 'hC3, 'h3C, 'hC3, 'h3C, 'hC3, 'h3C));
      send_frame(frame_of(MODE_SECTOR, 0, 'hFF, 'hFF, 'hFF, 'h01, 'h01, 'h01));
      wait_idle();
      write_csr(REG_SYMMETRIC, 0);
      send_frame(frame_of(MODE_FILL, 0, 'h10, 'h20, 'h30, 'h40, 'h50, 'h60));
      send_frame(frame_of(MODE_FILL, 1, 'h10, 'h20, 'h30, 'h40, 'h50, 'h60));
      wait_idle();

      // zero led count: frames taken and dropped, sector untouched
      write_csr(REG_LED_COUNT, 0);
      send_frame(frame_of(MODE_FILL, 60, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF));
      send_frame(frame_of(MODE_SECTOR, 60, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF));
      wait_idle();

      // led count above the strip maximum saturates
      write_csr(REG_LED_COUNT, 127);
      send_frame(frame_of(MODE_FILL, 70, 'hA5, 'h5A, 'hA5, 'h5A, 'hA5, 'h5A));
      wait_idle();

      // zero step: empty window that never moves; zero hold steps every frame
      write_csr(REG_LED_COUNT, 10);
      write_csr(REG_SECTOR_STEP, 0);
      write_csr(REG_SECTOR_HOLD, 0);
      send_frame(frame_of(MODE_SECTOR, 0, 'hFF, 'h00, 'h00, 'h00, 'h00, 'hFF));
      send_frame(frame_of(MODE_SECTOR, 0, 'hFF, 'h00, 'h00, 'h00, 'h00, 'hFF));
      wait_idle();

      // step beyond full scale wraps on every move
      write_csr(REG_SECTOR_STEP, 127);
      send_frame(frame_of(MODE_SECTOR, 0, 'h00, 'hFF, 'h00, 'hFF, 'h00, 'hFF));
      send_frame(frame_of(MODE_SECTOR, 0, 'h00, 'hFF, 'h00, 'hFF, 'h00, 'hFF));
      wait_idle();

      write_csr(REG_SECTOR_STEP, 100);
      write_csr(REG_SECTOR_HOLD, 1);
      send_frame(frame_of(MODE_SECTOR, 0, 'h80, 'h80, 'h80, 'h7F, 'h7F, 'h7F));
      send_frame(frame_of(MODE_SECTOR, 0, 'h80, 'h80, 'h80, 'h7F, 'h7F, 'h7F));
      wait_idle();

      write_csr(REG_SECTOR_STEP, 1);
      write_csr(REG_SECTOR_HOLD, 65535);
      // unused register slots must have no effect
      write_csr(CSR_IDX_W'(REG_SECTOR_HOLD + 1), 'hFFFF);
      write_csr(CSR_IDX_W'(REG_SECTOR_HOLD + 2), 'h5555);
      write_csr(CSR_IDX_W'(REG_SECTOR_HOLD + 3), 'hAAAA);
      send_frame(frame_of(MODE_SECTOR, 0, 'h01, 'h23, 'h45, 'h67, 'h89, 'hAB));

      // random phases, each with its own register setting and idling style
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         shuffle_registers();
         req_calm = ($urandom_range(0, 2) == 0);
         rsp_calm = ($urandom_range(0, 2) == 0);
         if (phase == PRESSURE_PHASE) begin
            // sink holds off while frames keep coming: the block has to back up
            write_csr(REG_LED_COUNT, CSR_DATA_W'(MAX_LEDS));
            req_calm     = 1'b1;
            rsp_hold_off = PRESSURE_CYCLES;
         end
         for (k = 0; k < PHASE_FRAMES; k++) send_frame(random_frame());
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/lbfr_pkg.sv
rtl/core/lbfr_window.sv
rtl/core/led_bar_frame_renderer.sv
rtl/core/lbfr_checker.sv
bench/testbench.sv
